// File: sv/ffba_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package ffba_pkg;

  localparam int SIZE_W   = 12;
  localparam int INDEX_W  = 10;
  localparam int STATUS_W = 2;

  // block overhead (header + footer) and smallest leftover worth splitting off
  localparam int TAG_OVERHEAD = 2;
  localparam int SPLIT_MIN    = 3;

  localparam logic REQ_ALLOC = 1'b0;
  localparam logic REQ_FREE  = 1'b1;

  localparam logic TAG_USED = 1'b0;
  localparam logic TAG_FREE = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK      = 2'd0,
    ST_NOSPACE = 2'd1,
    ST_NOTALLOC = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    RD_PTR   = 2'd0,
    RD_LEFT  = 2'd1,
    RD_RIGHT = 2'd2
  } rsel_t;

  typedef enum logic [3:0] {
    WR_NONE       = 4'd0,
    WR_INIT_HEAD  = 4'd1,
    WR_INIT_FOOT  = 4'd2,
    WR_ALLOC_HEAD = 4'd3,
    WR_ALLOC_FOOT = 4'd4,
    WR_REM_HEAD   = 4'd5,
    WR_REM_FOOT   = 4'd6,
    WR_FREE_HEAD  = 4'd7,
    WR_FREE_FOOT  = 4'd8
  } wsel_t;

  typedef struct packed {
    logic    capture;
    logic    walk_ev;
    logic    left_ev;
    logic    right_ev;
    logic    grant;
    logic    set_status;
    status_t status_code;
    rsel_t   rsel;
    wsel_t   wsel;
  } ffba_cmd_t;

  typedef struct packed {
    logic req_bad;
    logic free_req;
    logic hit;
    logic at_target;
    logic past_target;
    logic next_end;
    logic tag_free;
    logic split;
    logic base_zero;
    logic right_in;
  } ffba_flags_t;

endpackage

`default_nettype wire

// File: sv/ffba_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module ffba_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// File: sv/ffba_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module ffba_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  ffba_pkg::ffba_flags_t flags,
  output ffba_pkg::ffba_cmd_t   cmd,
  output logic                  busy,
  output logic                  done
);

  import ffba_pkg::*;

  typedef enum logic [15:0] {
    S_INIT_HEAD  = 16'h0001,
    S_INIT_FOOT  = 16'h0002,
    S_IDLE       = 16'h0004,
    S_WALK_RD    = 16'h0008,
    S_WALK_EV    = 16'h0010,
    S_ALLOC_HEAD = 16'h0020,
    S_ALLOC_FOOT = 16'h0040,
    S_REM_HEAD   = 16'h0080,
    S_REM_FOOT   = 16'h0100,
    S_LEFT_RD    = 16'h0200,
    S_LEFT_EV    = 16'h0400,
    S_RIGHT_RD   = 16'h0800,
    S_RIGHT_EV   = 16'h1000,
    S_FREE_HEAD  = 16'h2000,
    S_FREE_FOOT  = 16'h4000,
    S_DONE       = 16'h8000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_INIT_HEAD;
    end else begin
      state <= state_next;
    end
  end

  assign busy = (state != S_IDLE);
  assign done = (state == S_DONE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      S_INIT_HEAD: begin
        cmd.wsel   = WR_INIT_HEAD;
        state_next = S_INIT_FOOT;
      end
      S_INIT_FOOT: begin
        cmd.wsel   = WR_INIT_FOOT;
        state_next = S_IDLE;
      end
      S_IDLE: begin
        if (start) begin
          cmd.capture = 1'b1;
          if (flags.req_bad) begin
            cmd.set_status  = 1'b1;
            cmd.status_code = ST_NOTALLOC;
            state_next      = S_DONE;
          end else begin
            state_next = S_WALK_RD;
          end
        end
      end
      S_WALK_RD: begin
        cmd.rsel   = RD_PTR;
        state_next = S_WALK_EV;
      end
      S_WALK_EV: begin
        cmd.walk_ev = 1'b1;
        if (!flags.free_req) begin
          priority if (flags.hit) begin
            state_next = S_ALLOC_HEAD;
          end else if (flags.next_end) begin
            cmd.set_status  = 1'b1;
            cmd.status_code = ST_NOSPACE;
            state_next      = S_DONE;
          end else begin
            state_next = S_WALK_RD;
          end
        end else begin
          priority if (flags.at_target) begin
            if (flags.tag_free) begin
              cmd.set_status  = 1'b1;
              cmd.status_code = ST_NOTALLOC;
              state_next      = S_DONE;
            end else begin
              state_next = S_LEFT_RD;
            end
          end else if (flags.past_target || flags.next_end) begin
            cmd.set_status  = 1'b1;
            cmd.status_code = ST_NOTALLOC;
            state_next      = S_DONE;
          end else begin
            state_next = S_WALK_RD;
          end
        end
      end
      S_ALLOC_HEAD: begin
        cmd.wsel   = WR_ALLOC_HEAD;
        cmd.grant  = 1'b1;
        state_next = S_ALLOC_FOOT;
      end
      S_ALLOC_FOOT: begin
        cmd.wsel = WR_ALLOC_FOOT;
        if (flags.split) begin
          state_next = S_REM_HEAD;
        end else begin
          cmd.set_status  = 1'b1;
          cmd.status_code = ST_OK;
          state_next      = S_DONE;
        end
      end
      S_REM_HEAD: begin
        cmd.wsel   = WR_REM_HEAD;
        state_next = S_REM_FOOT;
      end
      S_REM_FOOT: begin
        cmd.wsel        = WR_REM_FOOT;
        cmd.set_status  = 1'b1;
        cmd.status_code = ST_OK;
        state_next      = S_DONE;
      end
      S_LEFT_RD: begin
        if (flags.base_zero) begin
          state_next = S_RIGHT_RD;
        end else begin
          cmd.rsel   = RD_LEFT;
          state_next = S_LEFT_EV;
        end
      end
      S_LEFT_EV: begin
        cmd.left_ev = 1'b1;
        state_next  = S_RIGHT_RD;
      end
      S_RIGHT_RD: begin
        if (flags.right_in) begin
          cmd.rsel   = RD_RIGHT;
          state_next = S_RIGHT_EV;
        end else begin
          state_next = S_FREE_HEAD;
        end
      end
      S_RIGHT_EV: begin
        cmd.right_ev = 1'b1;
        state_next   = S_FREE_HEAD;
      end
      S_FREE_HEAD: begin
        cmd.wsel   = WR_FREE_HEAD;
        state_next = S_FREE_FOOT;
      end
      S_FREE_FOOT: begin
        cmd.wsel        = WR_FREE_FOOT;
        cmd.set_status  = 1'b1;
        cmd.status_code = ST_OK;
        state_next      = S_DONE;
      end
      S_DONE: begin
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// File: sv/ffba_dp.sv
`timescale 1ns / 1ps
`default_nettype none

module ffba_dp #(
  parameter int HEAP_WORDS = 1024,
  parameter int WORD_BYTES = 4
) (
  input  logic                                  clk,
  input  logic                                  req_type,
  input  logic [ffba_pkg::SIZE_W-1:0]           req_size,
  input  logic [ffba_pkg::INDEX_W-1:0]          block_index,
  input  ffba_pkg::ffba_cmd_t                   cmd,
  output ffba_pkg::ffba_flags_t                 flags,
  output logic [ffba_pkg::STATUS_W-1:0]         status,
  output logic [ffba_pkg::INDEX_W-1:0]          granted_index
);

  import ffba_pkg::*;

  localparam int AW  = $clog2(HEAP_WORDS);
  localparam int TW  = AW + 1;                               // {payload words, free}
  localparam int CW  = ((AW > SIZE_W) ? AW : SIZE_W) + 2;    // walk arithmetic
  localparam int EW  = ((AW + 1) > INDEX_W) ? (AW + 1) : INDEX_W;
  // bytes to words: ceil via reciprocal multiply, exact for 13-bit dividends
  localparam int XW     = SIZE_W + 1;
  localparam int DIV_SH = 17;
  localparam int RECIP  = ((1 << DIV_SH) + WORD_BYTES - 1) / WORD_BYTES;
  localparam int PRW    = XW + DIV_SH + 1;

  logic [CW-1:0]     ptr;
  logic [AW-1:0]     base;
  logic [AW-1:0]     cur_w;
  logic              split_r;
  logic [AW-1:0]     start_r;
  logic [CW-1:0]     acc;
  logic [SIZE_W-1:0] need_r;
  logic [AW-1:0]     p_r;
  logic              free_req_r;
  logic [STATUS_W-1:0] status_q;
  logic [INDEX_W-1:0]  granted_q;

  logic [TW-1:0] rd_data;
  logic [AW-1:0] rd_w;
  logic          rd_free;
  logic [CW-1:0] rd_w_c, need_c, base_c, cur_w_c, start_c, ptr_next, p_c;
  logic [CW-1:0] take_c, rem_c, rd_addr_c, wr_addr_c;
  logic [TW-1:0] wr_data;
  logic          wr_en, wr_ok;
  logic [EW-1:0] blk_ext, base_g;
  logic [XW-1:0] bytes_up;
  logic [PRW-1:0] prod;
  logic [SIZE_W-1:0] quot, need_calc;

  assign rd_w    = rd_data[TW-1:1];
  assign rd_free = rd_data[0];
  assign rd_w_c  = CW'(rd_w);
  assign need_c  = CW'(need_r);
  assign base_c  = CW'(base);
  assign cur_w_c = CW'(cur_w);
  assign start_c = CW'(start_r);
  assign p_c     = CW'(p_r);
  assign ptr_next = ptr + rd_w_c + CW'(TAG_OVERHEAD);

  // request size to payload words, zero bytes served as one word
  assign bytes_up  = XW'(req_size) + XW'(WORD_BYTES - 1);
  assign prod      = PRW'(bytes_up) * PRW'(RECIP);
  assign quot      = prod[DIV_SH +: SIZE_W];
  assign need_calc = (quot == '0) ? SIZE_W'(1) : quot;

  assign blk_ext = EW'(block_index);
  assign base_g  = EW'(base);

  always_comb begin
    flags             = '0;
    flags.req_bad     = (req_type == REQ_FREE) && (blk_ext >= EW'(HEAP_WORDS));
    flags.free_req    = free_req_r;
    flags.hit         = rd_free && (rd_w_c >= need_c);
    flags.at_target   = (ptr == p_c);
    flags.past_target = (ptr > p_c);
    flags.next_end    = (ptr_next >= CW'(HEAP_WORDS));
    flags.tag_free    = rd_free;
    flags.split       = split_r;
    flags.base_zero   = (base == '0);
    flags.right_in    = ((base_c + cur_w_c + CW'(TAG_OVERHEAD)) < CW'(HEAP_WORDS));
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      free_req_r <= (req_type == REQ_FREE);
      need_r     <= need_calc;
      p_r        <= blk_ext[AW-1:0];
      ptr        <= '0;
      granted_q  <= '0;
    end
    if (cmd.walk_ev) begin
      base    <= ptr[AW-1:0];
      start_r <= ptr[AW-1:0];
      cur_w   <= rd_w;
      acc     <= rd_w_c;
      split_r <= (rd_w_c >= need_c + CW'(SPLIT_MIN));
      ptr     <= ptr_next;
    end
    if (cmd.left_ev && rd_free && (rd_w_c + CW'(TAG_OVERHEAD) <= base_c)) begin
      start_r <= AW'(base_c - rd_w_c - CW'(TAG_OVERHEAD));
      acc     <= acc + rd_w_c + CW'(TAG_OVERHEAD);
    end
    if (cmd.right_ev && rd_free) begin
      acc <= acc + rd_w_c + CW'(TAG_OVERHEAD);
    end
    if (cmd.grant) begin
      granted_q <= base_g[INDEX_W-1:0];
    end
    if (cmd.set_status) begin
      status_q <= cmd.status_code;
    end
  end

  assign take_c = split_r ? need_c : cur_w_c;
  assign rem_c  = cur_w_c - need_c - CW'(TAG_OVERHEAD);

  always_comb begin
    unique case (cmd.rsel)
      RD_PTR:   rd_addr_c = ptr;
      RD_LEFT:  rd_addr_c = base_c - CW'(1);
      RD_RIGHT: rd_addr_c = base_c + cur_w_c + CW'(TAG_OVERHEAD);
      default:  rd_addr_c = ptr;
    endcase
  end

  always_comb begin
    wr_en     = 1'b1;
    wr_addr_c = '0;
    wr_data   = '0;
    unique case (cmd.wsel)
      WR_NONE: begin
        wr_en = 1'b0;
      end
      WR_INIT_HEAD: begin
        wr_addr_c = '0;
        wr_data   = {AW'(HEAP_WORDS - TAG_OVERHEAD), TAG_FREE};
      end
      WR_INIT_FOOT: begin
        wr_addr_c = CW'(HEAP_WORDS - 1);
        wr_data   = {AW'(HEAP_WORDS - TAG_OVERHEAD), TAG_FREE};
      end
      WR_ALLOC_HEAD: begin
        wr_addr_c = base_c;
        wr_data   = {take_c[AW-1:0], TAG_USED};
      end
      WR_ALLOC_FOOT: begin
        wr_addr_c = base_c + take_c + CW'(1);
        wr_data   = {take_c[AW-1:0], TAG_USED};
      end
      WR_REM_HEAD: begin
        wr_addr_c = base_c + need_c + CW'(TAG_OVERHEAD);
        wr_data   = {rem_c[AW-1:0], TAG_FREE};
      end
      WR_REM_FOOT: begin
        wr_addr_c = base_c + cur_w_c + CW'(1);
        wr_data   = {rem_c[AW-1:0], TAG_FREE};
      end
      WR_FREE_HEAD: begin
        wr_addr_c = start_c;
        wr_data   = {acc[AW-1:0], TAG_FREE};
      end
      WR_FREE_FOOT: begin
        wr_addr_c = start_c + acc + CW'(1);
        wr_data   = {acc[AW-1:0], TAG_FREE};
      end
      default: begin
        wr_en = 1'b0;
      end
    endcase
  end

  // tags that would land past the heap end are dropped
  assign wr_ok = wr_en && (wr_addr_c < CW'(HEAP_WORDS));

  ffba_ram #(
    .WIDTH (TW),
    .DEPTH (HEAP_WORDS)
  ) u_tag_ram (
    .clk   (clk),
    .we    (wr_ok),
    .waddr (wr_addr_c[AW-1:0]),
    .wdata (wr_data),
    .raddr (rd_addr_c[AW-1:0]),
    .rdata (rd_data)
  );

  assign status        = status_q;
  assign granted_index = granted_q;

endmodule

`default_nettype wire

// File: sv/first_fit_block_allocator.sv
`timescale 1ns / 1ps
`default_nettype none

// First-fit heap allocator over a word-addressed tag memory of HEAP_WORDS
// entries, one free block spanning the heap after reset. A request is taken
// when start is high and busy is low; its single result appears on status and
// granted_index with done high for exactly one cycle, and must be captured
// then. After reset the block is busy while it writes the initial header and
// footer. An allocate visits the block headers in turn with one tag memory
// read and one evaluate each (so the walk grows with fragmentation), then makes
// 2 tag writes for a whole-block grant or 4 for a split, then gives the result
// and returns to idle. A free walks the headers from word 0 up to the named
// block the same way, then reads whichever neighbors lie inside the heap and
// writes the merged block's header and footer before giving the result.
// Requests are served one at a time; the tag memory has a single read port
// and a single write port.
module first_fit_block_allocator #(
  parameter int HEAP_WORDS = 1024,
  parameter int WORD_BYTES = 4
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic        req_type,
  input  logic [11:0] req_size,
  input  logic [9:0]  block_index,
  output logic        done,
  output logic [1:0]  status,
  output logic [9:0]  granted_index
);

  import ffba_pkg::*;

  // command and status between the sequencer and the tag datapath
  ffba_cmd_t   cmd;
  ffba_flags_t flags;

  // sequencer: walk, split, merge and result timing
  ffba_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .flags (flags),
    .cmd   (cmd),
    .busy  (busy),
    .done  (done)
  );

  // tag memory, walk pointer, size conversion and result registers
  ffba_dp #(
    .HEAP_WORDS (HEAP_WORDS),
    .WORD_BYTES (WORD_BYTES)
  ) u_dp (
    .clk           (clk),
    .req_type      (req_type),
    .req_size      (req_size),
    .block_index   (block_index),
    .cmd           (cmd),
    .flags         (flags),
    .status        (status),
    .granted_index (granted_index)
  );

  // the result strobe lasts a single cycle
  a_done_single: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("result strobe held for more than one cycle");

  // an accepted request keeps the block busy in the next cycle
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("block not busy after accepting a request");

  // a failed request reports no granted block
  a_grant_zero: assert property (@(posedge clk) disable iff (rst)
    (done && (status != ST_OK)) |-> (granted_index == '0))
    else $error("granted index nonzero on a failed request");

  // tag writes never coincide with a result
  a_no_write_done: assert property (@(posedge clk) disable iff (rst)
    done |-> ((cmd.wsel == WR_NONE) && !cmd.capture))
    else $error("tag write or capture during result cycle");

endmodule

`default_nettype wire
